[sv/tmfu_pkg.sv]
// Shared types, constants and arithmetic helpers of the molecular field update block.
package tmfu_pkg;

  localparam int NumElem = 9;

  // Reciprocal of six for the neighbor mean: floor(x / 6) equals
  // (x * Recip6) >> Recip6Shift for every x below 2^27.
  localparam logic [26:0] Recip6      = 27'd89478486;
  localparam int          Recip6Shift = 29;

  typedef enum logic [3:0] {
    REG_ELASTIC  = 4'd0,
    REG_COEFF_A  = 4'd1,
    REG_COEFF_B  = 4'd2,
    REG_COEFF_C  = 4'd3,
    REG_ANCHOR_U = 4'd4,
    REG_ANCHOR_D = 4'd5,
    REG_STEP     = 4'd6,
    REG_INV_HALF = 4'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_BULK = 2'd0,
    KIND_UNIF = 2'd1,
    KIND_DEGN = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  // One classified element from the front end, queued for the back end.
  typedef struct packed {
    logic [3:0]         idx;
    logic               last;
    kind_t              kind;
    logic signed [23:0] q;
    logic signed [27:0] lap;
    logic signed [31:0] surf;
    logic signed [24:0] adiff;
  } elem_t;

  typedef struct packed {
    logic signed [31:0] elastic;
    logic signed [31:0] coeff_a;
    logic signed [31:0] coeff_b;
    logic signed [31:0] coeff_c;
    logic signed [31:0] anchor_u;
    logic signed [31:0] anchor_d;
    logic [30:0]        step;
    logic [62:0]        inv_half;
  } cfg_t;

  function automatic logic signed [23:0] sat24(input logic signed [71:0] x);
    if (x > 72'sd8388607) return 24'sh7FFFFF;
    else if (x < -72'sd8388608) return 24'sh800000;
    else return x[23:0];
  endfunction

endpackage

[sv/tmfu_front.sv]
// Front end: takes elements, forms neighbor mean, gradient and anchoring difference.
module tmfu_front import tmfu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] q_elem,
  input  logic signed [23:0] top_elem,
  input  logic signed [23:0] bottom_elem,
  input  logic signed [23:0] left_elem,
  input  logic signed [23:0] right_elem,
  input  logic signed [23:0] front_elem,
  input  logic signed [23:0] back_elem,
  input  logic signed [23:0] bound_elem,
  input  logic signed [23:0] normal_x,
  input  logic signed [23:0] normal_y,
  input  logic signed [23:0] normal_z,
  input  logic [1:0]         point_kind,
  output logic               q_push,
  output elem_t              q_data,
  input  logic               q_full
);

  logic [3:0]         cnt_r, cnt_nxt;
  kind_t              kind_r, kind_nxt;
  logic signed [23:0] nx_r, ny_r, nz_r;
  logic               first;
  logic               in_acc;
  kind_t              kind_use;
  logic signed [23:0] nxu, nyu, nzu;
  logic signed [26:0] nsum, nabs;
  logic [26:0]        mnum, mq;
  logic [53:0]        mprod;
  logic signed [27:0] mean;
  logic signed [45:0] px, py, pz;
  logic signed [29:0] rx, ry, rz;
  // Stage register between the difference products and the normal weighting.
  logic               s_vld_r;
  logic [3:0]         s_idx_r;
  logic               s_last_r;
  kind_t              s_kind_r;
  logic signed [23:0] s_q_r;
  logic signed [27:0] s_lap_r;
  logic signed [24:0] s_adiff_r;
  logic signed [29:0] s_rx_r, s_ry_r, s_rz_r;
  logic signed [23:0] s_nx_r, s_ny_r, s_nz_r;
  logic signed [54:0] gsum;
  logic signed [34:0] gr;

  // The stage takes a new item when it is empty or hands its item on this cycle.
  assign in_ready = !s_vld_r || !q_full;
  assign in_acc   = in_valid && in_ready;
  assign q_push   = s_vld_r && !q_full;
  assign first    = (cnt_r == 4'd0);
  assign kind_use = first ? kind_t'(point_kind) : kind_r;
  assign nxu = first ? normal_x : nx_r;
  assign nyu = first ? normal_y : ny_r;
  assign nzu = first ? normal_z : nz_r;

  always_comb begin
    nsum = 27'(top_elem) + 27'(bottom_elem) + 27'(left_elem) + 27'(right_elem)
         + 27'(front_elem) + 27'(back_elem);
    nabs  = nsum[26] ? -nsum : nsum;
    mnum  = 27'(nabs + 27'sd3);
    mprod = 54'(mnum) * 54'(Recip6);
    mq    = 27'(mprod >> Recip6Shift);
    mean  = nsum[26] ? -28'(mq) : 28'(mq);
    px = 46'(25'(front_elem) - 25'(back_elem)) * $signed({1'b0, cfg.inv_half[20:0]});
    py = 46'(25'(left_elem) - 25'(right_elem)) * $signed({1'b0, cfg.inv_half[41:21]});
    pz = 46'(25'(top_elem) - 25'(bottom_elem)) * $signed({1'b0, cfg.inv_half[62:42]});
    rx = 30'((px + 46'sd32768) >>> 16);
    ry = 30'((py + 46'sd32768) >>> 16);
    rz = 30'((pz + 46'sd32768) >>> 16);
  end

  always_comb begin
    gsum = 55'(s_rx_r) * 55'(s_nx_r) + 55'(s_ry_r) * 55'(s_ny_r)
         + 55'(s_rz_r) * 55'(s_nz_r);
    gr = 35'((gsum + 55'sd524288) >>> 20);
    q_data.idx   = s_idx_r;
    q_data.last  = s_last_r;
    q_data.kind  = s_kind_r;
    q_data.q     = s_q_r;
    q_data.lap   = s_lap_r;
    q_data.surf  = (gr > 35'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                   (gr < -35'sh80000000) ? 32'sh80000000 : gr[31:0];
    q_data.adiff = s_adiff_r;
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    kind_nxt = kind_r;
    if (in_acc) begin
      cnt_nxt  = (cnt_r == 4'(NumElem - 1)) ? 4'd0 : cnt_r + 4'd1;
      kind_nxt = kind_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 4'd0;
      kind_r  <= KIND_BULK;
      s_vld_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      kind_r <= kind_nxt;
      if (in_acc) s_vld_r <= 1'b1;
      else if (q_push) s_vld_r <= 1'b0;
    end
    if (in_acc && first) begin
      nx_r <= normal_x;
      ny_r <= normal_y;
      nz_r <= normal_z;
    end
    if (in_acc) begin
      s_idx_r   <= cnt_r;
      s_last_r  <= (cnt_r == 4'(NumElem - 1));
      s_kind_r  <= kind_use;
      s_q_r     <= q_elem;
      s_lap_r   <= mean - 28'(q_elem);
      s_adiff_r <= 25'(q_elem) - 25'(bound_elem);
      s_rx_r    <= rx;
      s_ry_r    <= ry;
      s_rz_r    <= rz;
      s_nx_r    <= nxu;
      s_ny_r    <= nyu;
      s_nz_r    <= nzu;
    end
  end

endmodule

[sv/tmfu_fifo.sv]
// Short element queue between the front and back ends.
module tmfu_fifo import tmfu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  elem_t wdata,
  output logic  full,
  input  logic  pop,
  output logic  nempty,
  output elem_t rdata
);

  elem_t      mem_r [4];
  logic [2:0] wp_r, rp_r;

  assign full   = (wp_r - rp_r) == 3'd4;
  assign nempty = wp_r != rp_r;
  assign rdata  = mem_r[rp_r[1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 3'd0;
      rp_r <= 3'd0;
    end else begin
      if (push) wp_r <= wp_r + 3'd1;
      if (pop)  rp_r <= rp_r + 3'd1;
    end
    if (push) mem_r[wp_r[1:0]] <= wdata;
  end

endmodule

[sv/tmfu_back.sv]
// Back end: stores a point, then computes field and update per element with a shared multiplier.
module tmfu_back import tmfu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_nempty,
  input  elem_t              q_data,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [3:0]         element_index,
  output logic signed [23:0] field_value,
  output logic signed [23:0] updated_q,
  output logic               last_of_point
);

  typedef enum logic [2:0] {
    ST_LOAD, ST_TRACE, ST_CT, ST_SQ, ST_TERM, ST_SUM, ST_UPD, ST_OUT
  } st_t;

  st_t                st_r, st_nxt;
  logic signed [23:0] ts_r [NumElem];
  logic signed [27:0] ls_r [NumElem];
  logic signed [31:0] ss_r [NumElem];
  logic signed [24:0] ds_r [NumElem];
  kind_t              kind_r;
  logic [3:0]         i_r, i_nxt;
  logic [2:0]         k_r, k_nxt;
  logic signed [53:0] acc_r, acc_nxt;
  logic signed [38:0] ct_r, ct_nxt;
  logic signed [63:0] h_r, h_nxt;
  logic signed [23:0] hs_r, hs_nxt;
  logic signed [23:0] nq_r, nq_nxt;
  logic signed [71:0] prod;
  logic signed [39:0] mul_a;
  logic signed [31:0] mul_b;
  logic [1:0]         row, col;
  logic [3:0]         ia, ib;
  logic               surf;
  logic signed [31:0] w;
  logic signed [63:0] tmp;
  logic signed [71:0] nqw;

  assign surf = (kind_r == KIND_UNIF) || (kind_r == KIND_DEGN);
  assign w    = (kind_r == KIND_UNIF) ? cfg.anchor_u : cfg.anchor_d;
  assign row  = (i_r >= 4'd6) ? 2'd2 : (i_r >= 4'd3) ? 2'd1 : 2'd0;
  assign col  = 2'(i_r - 4'(row) * 4'd3);
  assign ia   = 4'(row) * 4'd3 + 4'(k_r[1:0]);
  assign ib   = 4'(k_r[1:0]) * 4'd3 + 4'(col);
  assign prod = 72'(mul_a) * 72'(mul_b);

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; k_nxt = k_r; acc_nxt = acc_r; ct_nxt = ct_r;
    h_nxt = h_r; hs_nxt = hs_r; nq_nxt = nq_r; q_pop = 1'b0;
    mul_a = '0; mul_b = '0; tmp = '0; nqw = '0;
    out_tvalid = 1'b0;
    unique case (st_r)
      ST_LOAD: begin
        if (q_nempty) begin
          q_pop = 1'b1;
          if (q_data.last) begin
            st_nxt = ST_TRACE; i_nxt = 4'd0; acc_nxt = '0;
          end
        end
      end
      ST_TRACE: begin
        mul_a = 40'(ts_r[i_r]); mul_b = 32'(ts_r[i_r]);
        acc_nxt = acc_r + 54'(prod);
        if (i_r == 4'(NumElem - 1)) st_nxt = ST_CT;
        else i_nxt = i_r + 4'd1;
      end
      ST_CT: begin
        mul_a = 40'(cfg.coeff_c); mul_b = 32'((acc_r + 54'sd524288) >>> 20);
        tmp = 64'((prod + 72'sd32768) >>> 16);
        ct_nxt = (tmp > 64'sh3FFFFFFFFF) ? 39'sh3FFFFFFFFF :
                 (tmp < -64'sh4000000000) ? 39'sh4000000000 : tmp[38:0];
        i_nxt = 4'd0; k_nxt = 3'd0; acc_nxt = '0; h_nxt = '0;
        st_nxt = ST_SQ;
      end
      ST_SQ: begin
        if (surf) begin
          st_nxt = ST_TERM; k_nxt = 3'd0;
        end else begin
          mul_a = 40'(ts_r[ia]); mul_b = 32'(ts_r[ib]);
          acc_nxt = acc_r + 54'(prod);
          if (k_r == 3'd2) begin
            st_nxt = ST_TERM; k_nxt = 3'd0;
          end else k_nxt = k_r + 3'd1;
        end
      end
      ST_TERM: begin
        // One coefficient product per cycle, accumulated into h.
        if (surf) begin
          unique case (k_r)
            3'd0: begin mul_a = 40'(cfg.elastic); mul_b = 32'(ss_r[i_r]); end
            default: begin mul_a = 40'(w); mul_b = 32'(ds_r[i_r]); end
          endcase
          h_nxt = h_r + 64'((prod + 72'sd32768) >>> 16);
          if (k_r == 3'd1) st_nxt = ST_SUM;
          k_nxt = k_r + 3'd1;
        end else begin
          unique case (k_r)
            3'd0: begin mul_a = 40'(cfg.elastic); mul_b = 32'(ls_r[i_r]); end
            3'd1: begin mul_a = 40'(cfg.coeff_a); mul_b = 32'(ts_r[i_r]); end
            3'd2: begin
              mul_a = 40'(cfg.coeff_b);
              mul_b = 32'((acc_r + 54'sd524288) >>> 20);
            end
            default: begin mul_a = 40'(ct_r); mul_b = 32'(ts_r[i_r]); end
          endcase
          if (k_r == 3'd0) h_nxt = h_r + 64'((prod + 72'sd32768) >>> 16);
          else if (k_r == 3'd3) h_nxt = h_r - 64'((prod + 72'sd524288) >>> 20);
          else h_nxt = h_r - 64'((prod + 72'sd32768) >>> 16);
          if (k_r == 3'd3) st_nxt = ST_SUM;
          k_nxt = k_r + 3'd1;
        end
      end
      ST_SUM: begin
        hs_nxt = sat24(72'(h_r));
        st_nxt = ST_UPD;
      end
      ST_UPD: begin
        mul_a = 40'($signed({1'b0, cfg.step})); mul_b = 32'(hs_r);
        nqw = 72'(ts_r[i_r]) + ((prod + 72'sd32768) >>> 16);
        nq_nxt = sat24(nqw);
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          acc_nxt = '0; h_nxt = '0; k_nxt = 3'd0;
          if (i_r == 4'(NumElem - 1)) st_nxt = ST_LOAD;
          else begin
            i_nxt = i_r + 4'd1; st_nxt = ST_SQ;
          end
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  assign element_index = i_r;
  assign field_value   = hs_r;
  assign updated_q     = nq_r;
  assign last_of_point = (i_r == 4'(NumElem - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD;
      i_r  <= 4'd0;
      k_r  <= 3'd0;
    end else begin
      st_r <= st_nxt;
      i_r  <= i_nxt;
      k_r  <= k_nxt;
    end
    acc_r <= acc_nxt; ct_r <= ct_nxt; h_r <= h_nxt; hs_r <= hs_nxt; nq_r <= nq_nxt;
    if (q_pop) begin
      ts_r[q_data.idx] <= q_data.q;
      ls_r[q_data.idx] <= q_data.lap;
      ss_r[q_data.idx] <= q_data.surf;
      ds_r[q_data.idx] <= q_data.adiff;
      kind_r <= q_data.kind;
    end
  end

endmodule

[sv/tensor_molecular_field_update.sv]
// The back end stores a point's nine items, then computes its results one element
// after another with its single shared multiplier; a front stage and a four-entry
// queue keep taking items while the back end works, until both are full.
// Reset (rst_n low, synchronous) clears counters, state, valid flags and the
// configuration registers; tensor stores and data registers are written before
// they are read and need no clearing.
module tensor_molecular_field_update import tmfu_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_index,
  input  logic [62:0]   cfg_data,
  input  logic          in_tvalid,
  output logic          in_tready,
  // tdata: q_elem, top, bottom, left, right, front, back, bound, normal_x/y/z (24 each)
  input  logic [263:0]  in_tdata,
  input  logic [1:0]    in_tuser,   // point_kind
  output logic          out_tvalid,
  input  logic          out_tready,
  // tdata: element_index[3:0], field_value[27:4], updated_q[51:28], zero pad
  output logic [55:0]   out_tdata,
  output logic          out_tlast   // last_of_point
);

  cfg_t  cfg_r;
  elem_t f_data, b_data;
  logic  f_push, f_full, b_pop, b_nempty;
  logic [3:0] oi;
  logic signed [23:0] ofv, oq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ELASTIC:  cfg_r.elastic  <= cfg_data[31:0];
        REG_COEFF_A:  cfg_r.coeff_a  <= cfg_data[31:0];
        REG_COEFF_B:  cfg_r.coeff_b  <= cfg_data[31:0];
        REG_COEFF_C:  cfg_r.coeff_c  <= cfg_data[31:0];
        REG_ANCHOR_U: cfg_r.anchor_u <= cfg_data[31:0];
        REG_ANCHOR_D: cfg_r.anchor_d <= cfg_data[31:0];
        REG_STEP:     cfg_r.step     <= cfg_data[30:0];
        REG_INV_HALF: cfg_r.inv_half <= cfg_data;
        default: ;
      endcase
    end
  end

  tmfu_front u_front (
    .clk, .rst_n, .cfg(cfg_r), .in_valid(in_tvalid), .in_ready(in_tready),
    .q_elem(in_tdata[23:0]), .top_elem(in_tdata[47:24]), .bottom_elem(in_tdata[71:48]),
    .left_elem(in_tdata[95:72]), .right_elem(in_tdata[119:96]),
    .front_elem(in_tdata[143:120]), .back_elem(in_tdata[167:144]),
    .bound_elem(in_tdata[191:168]), .normal_x(in_tdata[215:192]),
    .normal_y(in_tdata[239:216]), .normal_z(in_tdata[263:240]),
    .point_kind(in_tuser), .q_push(f_push), .q_data(f_data), .q_full(f_full)
  );

  tmfu_fifo u_fifo (
    .clk, .rst_n, .push(f_push), .wdata(f_data), .full(f_full),
    .pop(b_pop), .nempty(b_nempty), .rdata(b_data)
  );

  tmfu_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_nempty(b_nempty), .q_data(b_data), .q_pop(b_pop),
    .out_tvalid, .out_tready, .element_index(oi), .field_value(ofv),
    .updated_q(oq), .last_of_point(out_tlast)
  );

  assign out_tdata = {4'd0, oq, ofv, oi};

endmodule

[sim/tensor_molecular_field_update_checker.sv]
// Checker that predicts and compares the molecular field update results.
`timescale 1ns / 1ps
module tensor_molecular_field_update_checker import tmfu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_index,
  input  logic [62:0]  cfg_data,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [263:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [55:0]  out_tdata,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [3:0]  idx;
    logic [23:0] h;
    logic [23:0] nq;
    logic        last;
  } field_res_t;

  field_res_t field_q[$];
  cfg_t cfg;
  longint t_st[NumElem], lap_st[NumElem], surf_st[NumElem], diff_st[NumElem];
  longint norm[3];
  int elem_cnt;
  kind_t kind_h;

  assign pending = field_q.size();

  function automatic longint rnd(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat(longint x, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  function automatic longint s24(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  // Takes one input item; on the ninth element queues nine results.
  task automatic absorb_element(logic [263:0] d, logic [1:0] k);
    longint v[11];
    longint s, m, ix, iy, iz, g, tr, ct, h, sq, w, qi, nq;
    int r, c;
    field_res_t e;
    for (int i = 0; i < 11; i++) v[i] = s24(d[i*24 +: 24]);
    if (elem_cnt == 0) begin
      kind_h = kind_t'(k);
      norm[0] = v[8]; norm[1] = v[9]; norm[2] = v[10];
    end
    t_st[elem_cnt] = v[0];
    s = v[1] + v[2] + v[3] + v[4] + v[5] + v[6];
    m = s < 0 ? -((-s + 3) / 6) : (s + 3) / 6;
    lap_st[elem_cnt] = m - v[0];
    ix = longint'(cfg.inv_half[20:0]);
    iy = longint'(cfg.inv_half[41:21]);
    iz = longint'(cfg.inv_half[62:42]);
    g = rnd((v[5] - v[6]) * ix, 16) * norm[0] + rnd((v[3] - v[4]) * iy, 16) * norm[1]
      + rnd((v[1] - v[2]) * iz, 16) * norm[2];
    surf_st[elem_cnt] = sat(rnd(g, 20), 32);
    diff_st[elem_cnt] = v[0] - v[7];
    if (elem_cnt < NumElem - 1) begin
      elem_cnt++;
      return;
    end
    elem_cnt = 0;
    tr = 0;
    for (int i = 0; i < NumElem; i++) tr += t_st[i] * t_st[i];
    tr = rnd(tr, 20);
    ct = sat(rnd(longint'(cfg.coeff_c) * tr, 16), 39);
    for (int i = 0; i < NumElem; i++) begin
      r = i / 3; c = i % 3;
      qi = t_st[i];
      if (kind_h == KIND_UNIF || kind_h == KIND_DEGN) begin
        w = kind_h == KIND_UNIF ? longint'(cfg.anchor_u) : longint'(cfg.anchor_d);
        h = rnd(longint'(cfg.elastic) * surf_st[i], 16) + rnd(w * diff_st[i], 16);
      end else begin
        sq = 0;
        for (int j = 0; j < 3; j++) sq += t_st[r*3+j] * t_st[j*3+c];
        sq = rnd(sq, 20);
        h = rnd(longint'(cfg.elastic) * lap_st[i], 16) - rnd(longint'(cfg.coeff_a) * qi, 16)
          - rnd(longint'(cfg.coeff_b) * sq, 16) - rnd(ct * qi, 20);
      end
      h = sat(h, 24);
      nq = sat(qi + rnd(longint'(cfg.step) * h, 16), 24);
      e.idx = 4'(i); e.h = h[23:0]; e.nq = nq[23:0]; e.last = (i == NumElem - 1);
      field_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    field_res_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      cfg <= '0;
      elem_cnt = 0;
      kind_h = KIND_BULK;
      norm = '{0, 0, 0};
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ELASTIC:  cfg.elastic  <= cfg_data[31:0];
          REG_COEFF_A:  cfg.coeff_a  <= cfg_data[31:0];
          REG_COEFF_B:  cfg.coeff_b  <= cfg_data[31:0];
          REG_COEFF_C:  cfg.coeff_c  <= cfg_data[31:0];
          REG_ANCHOR_U: cfg.anchor_u <= cfg_data[31:0];
          REG_ANCHOR_D: cfg.anchor_d <= cfg_data[31:0];
          REG_STEP:     cfg.step     <= cfg_data[30:0];
          REG_INV_HALF: cfg.inv_half <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) absorb_element(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (field_q.size() == 0) begin
          $error("unexpected result idx=%0d", out_tdata[3:0]);
          errs++;
        end else begin
          e = field_q.pop_front();
          if (out_tdata[3:0] !== e.idx) begin
            $error("element_index expected %0d actual %0d", e.idx, out_tdata[3:0]);
            errs++;
          end
          if (out_tdata[27:4] !== e.h) begin
            $error("field_value expected %h actual %h", e.h, out_tdata[27:4]);
            errs++;
          end
          if (out_tdata[51:28] !== e.nq) begin
            $error("updated_q expected %h actual %h", e.nq, out_tdata[51:28]);
            errs++;
          end
          if (out_tlast !== e.last) begin
            $error("last_of_point expected %0d actual %0d", e.last, out_tlast);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

[sim/tensor_molecular_field_update_tb.sv]
// Testbench top: drives configuration and grid-point items, and gives the verdict.
`timescale 1ns / 1ps
module tensor_molecular_field_update_tb;
  import tmfu_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [3:0]   cfg_index = '0;
  logic [62:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [263:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [55:0]  out_tdata;
  logic         out_tlast;
  int           fail_count;
  int           pending;
  // While set, the receiver refuses every result so the input queue backs up.
  logic         hold_off = 1'b0;

  always #1 clk = ~clk;

  tensor_molecular_field_update dut (.*);

  tensor_molecular_field_update_checker chk (.*);

  // Random gap length: mostly zero or short, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [62:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A random Q3.20 value, biased toward the extremes now and then.
  function automatic logic [23:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h0;
      3, 4: return 24'($signed($urandom_range(0, 4194304)) - 2097152);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return 32'($signed($urandom_range(0, 262144)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  // Offers one item and waits for acceptance; gap is idle cycles beforehand.
  task automatic send_item(logic [263:0] d, logic [1:0] k, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= k;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Sends one grid point of nine elements; fill selects the element content.
  task automatic send_point(logic [1:0] k, int fill, bit gaps);
    logic [263:0] d;
    for (int e = 0; e < NumElem; e++) begin
      for (int f = 0; f < 11; f++) begin
        case (fill)
          1: d[f*24 +: 24] = 24'h7FFFFF;
          2: d[f*24 +: 24] = 24'h800000;
          3: d[f*24 +: 24] = (f % 2) ? 24'h7FFFFF : 24'h800000;
          default: d[f*24 +: 24] = rand_elem();
        endcase
      end
      send_item(d, k, gaps ? gap_len() : 0);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    // Let the checker take the last accepted item before looking at its queue.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // The last result can leave before the block is fully idle; give it room.
    repeat (40) @(posedge clk);
  endtask

  task automatic load_config(bit extreme);
    for (int r = 0; r < 6; r++)
      write_reg(reg_idx_t'(r), extreme ? (r % 2 ? 63'h80000000 : 63'h7FFFFFFF)
                                       : 63'(rand_coeff()));
    write_reg(REG_STEP, extreme ? 63'h7FFFFFFF : 63'($urandom_range(0, 131072)));
    write_reg(REG_INV_HALF, extreme ? {63{1'b1}} : 63'({$urandom, $urandom}));
  endtask

  // Receiver: random stalls, plus the long hold-off while hold_off is set.
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Receiver hold-off counted in its own process.
  task automatic long_hold();
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: zero registers first, then extreme registers with edge
    // tensors, bulk, uniform and reserved point kinds (reserved treated as bulk).
    send_point(KIND_BULK, 0, 0);
    wait_idle();
    load_config(1);
    send_point(KIND_BULK, 1, 0);
    send_point(KIND_UNIF, 2, 0);
    wait_idle();
    write_reg(reg_idx_t'(4'd9), 63'h5);  // unmapped index is ignored
    send_point(KIND_RSVD, 3, 1);
    wait_idle();

    // Random part across several settings; one phase stalls the receiver
    // for a long stretch while points keep arriving.
    for (int ph = 0; ph < 4; ph++) begin
      load_config(0);
      fork
        if (ph == 1) long_hold();
        for (int p = 0; p < 4; p++) send_point(2'($urandom_range(0, 3)), 0, ph != 1);
      join
      wait_idle();
    end
    if (fail_count == 0) begin
      $display("tensor_molecular_field_update_tb OK");
    end else begin
      $display("tensor_molecular_field_update_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tensor_molecular_field_update_tb NOT OK");
    $finish;
  end

endmodule

[sim.f]
sv/tmfu_pkg.sv
sv/tmfu_front.sv
sv/tmfu_fifo.sv
sv/tmfu_back.sv
sv/tensor_molecular_field_update.sv
sim/tensor_molecular_field_update_checker.sv
sim/tensor_molecular_field_update_tb.sv
